// ----- rtl/mtli_pkg.sv -----
// Shared types and constants for the clamped table interpolator.
`timescale 1ns / 1ps

package mtli_pkg;

    localparam int LEN_W  = 7;
    localparam int SLOT_W = 6;

    localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_WALK_RD,
        ST_WALK_CMP,
        ST_EDGE_RD,
        ST_EDGE_CAP,
        ST_PAIR_RD,
        ST_PAIR_CAP,
        ST_PREV_CAP,
        ST_PREP,
        ST_MUL,
        ST_DIV_INIT,
        ST_DIV,
        ST_FINISH,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        RD_WALK,
        RD_EDGE,
        RD_PAIR,
        RD_PREV
    } rd_sel_t;

    typedef struct packed {
        logic    accept;
        logic    write;
        logic    step;
        rd_sel_t rd_sel;
        logic    cap_xn;
        logic    cap_edge;
        logic    cap_pair;
        logic    cap_prev;
        logic    prep;
        logic    mul_step;
        logic    div_init;
        logic    div_step;
        logic    finish;
        logic    out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic is_query;
        logic ptr_ge_len;
        logic ptr_zero;
        logic x_ge;
        logic den_zero;
        logic iter_last;
        logic out_free;
    } dp_status_t;

endpackage

// ----- rtl/mtli_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mtli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/mtli_ctrl.sv -----
// Sequencer: walks the interval pointer, fetches breakpoints, runs multiply and divide.
`timescale 1ns / 1ps

module mtli_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mtli_pkg::dp_status_t status,
    output mtli_pkg::dp_cmd_t    cmd
);

    import mtli_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_WALK;
        s_ready    = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (status.is_query) begin
                    state_next = ST_WALK_RD;
                end else begin
                    cmd.write  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_WALK_RD: begin
                if (status.ptr_ge_len) begin
                    state_next = ST_EDGE_RD;
                end else begin
                    cmd.rd_sel = RD_WALK;
                    state_next = ST_WALK_CMP;
                end
            end
            ST_WALK_CMP: begin
                if (status.x_ge) begin
                    cmd.step   = 1'b1;
                    state_next = ST_WALK_RD;
                end else begin
                    cmd.cap_xn = 1'b1;
                    state_next = status.ptr_zero ? ST_EDGE_RD : ST_PAIR_RD;
                end
            end
            ST_EDGE_RD: begin
                cmd.rd_sel = RD_EDGE;
                state_next = ST_EDGE_CAP;
            end
            ST_EDGE_CAP: begin
                cmd.cap_edge = 1'b1;
                state_next   = ST_OUT;
            end
            ST_PAIR_RD: begin
                cmd.rd_sel = RD_PAIR;
                state_next = ST_PAIR_CAP;
            end
            ST_PAIR_CAP: begin
                cmd.cap_pair = 1'b1;
                cmd.rd_sel   = RD_PREV;
                state_next   = ST_PREV_CAP;
            end
            ST_PREV_CAP: begin
                cmd.cap_prev = 1'b1;
                state_next   = ST_PREP;
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = status.den_zero ? ST_OUT : ST_MUL;
            end
            ST_MUL: begin
                cmd.mul_step = 1'b1;
                if (status.iter_last) begin
                    state_next = ST_DIV_INIT;
                end
            end
            ST_DIV_INIT: begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.iter_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/mtli_dp.sv -----
// Datapath: breakpoint RAMs, pointer, shift-add multiplier, restoring divider, output word.
`timescale 1ns / 1ps

module mtli_dp #(
    parameter int TABLE_DEPTH = 64,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic [mtli_pkg::LEN_W-1:0]    cfg_table_len,
    input  logic                          s_req_type,
    input  logic [mtli_pkg::SLOT_W-1:0]   s_point_index,
    input  logic signed [DATA_WIDTH-1:0]  s_x_value,
    input  logic signed [DATA_WIDTH-1:0]  s_y_value,
    input  logic                          s_last_query,
    input  logic                          m_ready,
    output logic                          m_valid,
    output logic signed [DATA_WIDTH-1:0]  m_y_out,
    output logic                          m_batch_end,
    input  mtli_pkg::dp_cmd_t             cmd,
    output mtli_pkg::dp_status_t          status
);

    import mtli_pkg::*;

    localparam int DW      = DATA_WIDTH;
    localparam int AW      = $clog2(TABLE_DEPTH);
    localparam int CW      = $clog2(DATA_WIDTH);
    localparam int LEN_MAX = (1 << LEN_W) - 1;
    localparam int LEN_CAP = (TABLE_DEPTH < LEN_MAX) ? TABLE_DEPTH : LEN_MAX;

    function automatic logic [AW-1:0] to_addr(input logic [LEN_W-1:0] v);
        logic [LEN_W+AW-1:0] wide;
        wide = {{AW{1'b0}}, v};
        return wide[AW-1:0];
    endfunction

    function automatic logic [DW-1:0] mag(input logic [DW:0] v);
        logic [DW:0] n;
        n = v[DW] ? (~v + 1'b1) : v;
        return n[DW-1:0];
    endfunction

    // control state
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] ptr_reg;
    logic             m_valid_reg;

    // request and working registers
    logic                 req_type_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic signed [DW-1:0] x_reg;
    logic signed [DW-1:0] y_reg;
    logic                 last_reg;
    logic [DW-1:0]        xn_reg;
    logic [DW-1:0]        xm_reg;
    logic [DW-1:0]        yn_reg;
    logic [DW-1:0]        ym_reg;
    logic [DW-1:0]        mcand_reg;
    logic [DW-1:0]        den_reg;
    logic [2*DW-1:0]      prod_reg;
    logic                 neg_reg;
    logic                 ovf_reg;
    logic [CW-1:0]        cnt_reg;
    logic [DW-1:0]        res_reg;
    logic [DW-1:0]        m_y_reg;
    logic                 m_last_reg;

    logic [LEN_W-1:0]     len_eff;
    logic [LEN_W-1:0]     ptr_m1;
    logic [LEN_W-1:0]     edge_idx;
    logic [AW-1:0]        x_raddr;
    logic [AW-1:0]        y_raddr;
    logic [AW-1:0]        waddr;
    logic                 slot_ok;
    logic                 ram_we;
    logic signed [DW-1:0] x_rd;
    logic [DW-1:0]        y_rd;

    logic [DW:0]          dy_w;
    logic [DW:0]          dx_w;
    logic [DW:0]          den_w;
    logic [DW:0]          mul_sum;
    logic [DW:0]          div_t;
    logic [DW:0]          div_diff;
    logic                 div_ge;
    logic [DW-1:0]        div_rem;
    logic [DW:0]          q_mag;
    logic [DW+1:0]        q_ext;
    logic [DW+1:0]        q_sgn;
    logic [DW+1:0]        sum_w;
    logic [DW-1:0]        sat_w;

    // effective length: zero acts as one, clip to the table depth
    always_comb begin
        if (len_reg == '0) begin
            len_eff = LEN_W'(1);
        end else if (int'(len_reg) > LEN_CAP) begin
            len_eff = LEN_W'(LEN_CAP);
        end else begin
            len_eff = len_reg;
        end
    end

    assign ptr_m1   = ptr_reg - LEN_W'(1);
    assign edge_idx = status.ptr_ge_len ? (len_eff - LEN_W'(1)) : '0;

    always_comb begin
        unique case (cmd.rd_sel)
            RD_WALK: begin
                x_raddr = to_addr(ptr_reg);
                y_raddr = to_addr(ptr_reg);
            end
            RD_EDGE: begin
                x_raddr = to_addr(ptr_reg);
                y_raddr = to_addr(edge_idx);
            end
            RD_PAIR: begin
                x_raddr = to_addr(ptr_m1);
                y_raddr = to_addr(ptr_reg);
            end
            RD_PREV: begin
                x_raddr = to_addr(ptr_reg);
                y_raddr = to_addr(ptr_m1);
            end
            default: begin
                x_raddr = to_addr(ptr_reg);
                y_raddr = to_addr(ptr_reg);
            end
        endcase
    end

    assign slot_ok = int'(slot_reg) < TABLE_DEPTH;
    assign ram_we  = cmd.write && slot_ok;
    assign waddr   = to_addr(LEN_W'(slot_reg));

    mtli_ram #(
        .WIDTH (DW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram_x (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (x_reg),
        .raddr (x_raddr),
        .rdata (x_rd)
    );

    mtli_ram #(
        .WIDTH (DW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram_y (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (y_reg),
        .raddr (y_raddr),
        .rdata (y_rd)
    );

    // interval differences, one bit wider than the data
    assign dy_w  = {ym_reg[DW-1], ym_reg} - {yn_reg[DW-1], yn_reg};
    assign dx_w  = {x_reg[DW-1], x_reg} - {xn_reg[DW-1], xn_reg};
    assign den_w = {xm_reg[DW-1], xm_reg} - {xn_reg[DW-1], xn_reg};

    // shift-add multiply step: multiplier sits in the low half
    assign mul_sum = {1'b0, prod_reg[2*DW-1:DW]}
                   + {1'b0, (prod_reg[0] ? mcand_reg : {DW{1'b0}})};

    // restoring divide step: remainder in the high half, quotient shifts into the low half
    assign div_t    = {prod_reg[2*DW-1:DW], prod_reg[DW-1]};
    assign div_ge   = div_t >= {1'b0, den_reg};
    assign div_diff = div_t - {1'b0, den_reg};
    assign div_rem  = div_ge ? div_diff[DW-1:0] : div_t[DW-1:0];

    // signed sum and saturation; a quotient of 2^DW or more saturates anyway
    assign q_mag = ovf_reg ? {1'b1, {DW{1'b0}}} : {1'b0, prod_reg[DW-1:0]};
    assign q_ext = {1'b0, q_mag};
    assign q_sgn = neg_reg ? (~q_ext + 1'b1) : q_ext;
    assign sum_w = {{2{yn_reg[DW-1]}}, yn_reg} + q_sgn;

    always_comb begin
        if ((sum_w[DW+1:DW-1] == 3'b000) || (sum_w[DW+1:DW-1] == 3'b111)) begin
            sat_w = sum_w[DW-1:0];
        end else if (sum_w[DW+1]) begin
            sat_w = {1'b1, {(DW-1){1'b0}}};
        end else begin
            sat_w = {1'b0, {(DW-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= LEN_RESET;
            ptr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                len_reg <= cfg_table_len;
            end
            if (cmd.step) begin
                ptr_reg <= ptr_reg + LEN_W'(1);
            end else if (cmd.out_load && last_reg) begin
                ptr_reg <= '0;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            req_type_reg <= s_req_type;
            slot_reg     <= s_point_index;
            x_reg        <= s_x_value;
            y_reg        <= s_y_value;
            last_reg     <= s_last_query;
        end
        if (cmd.cap_xn) begin
            xn_reg <= x_rd;
        end
        if (cmd.cap_pair) begin
            xm_reg <= x_rd;
            yn_reg <= y_rd;
        end
        if (cmd.cap_prev) begin
            ym_reg <= y_rd;
        end
        if (cmd.cap_edge) begin
            res_reg <= y_rd;
        end
        if (cmd.prep) begin
            mcand_reg <= mag(dy_w);
            den_reg   <= mag(den_w);
            prod_reg  <= {{DW{1'b0}}, mag(dx_w)};
            neg_reg   <= dy_w[DW] ^ dx_w[DW] ^ den_w[DW];
            cnt_reg   <= CW'(DW - 1);
            res_reg   <= ym_reg;
        end
        if (cmd.mul_step) begin
            prod_reg <= {mul_sum, prod_reg[DW-1:1]};
            cnt_reg  <= cnt_reg - CW'(1);
        end
        if (cmd.div_init) begin
            ovf_reg <= prod_reg[2*DW-1:DW] >= den_reg;
            cnt_reg <= CW'(DW - 1);
        end
        if (cmd.div_step) begin
            prod_reg <= {div_rem, prod_reg[DW-2:0], div_ge};
            cnt_reg  <= cnt_reg - CW'(1);
        end
        if (cmd.finish) begin
            res_reg <= sat_w;
        end
        if (cmd.out_load) begin
            m_y_reg    <= res_reg;
            m_last_reg <= last_reg;
        end
    end

    assign status.is_query   = (req_type_reg == REQ_QUERY);
    assign status.ptr_ge_len = ptr_reg >= len_eff;
    assign status.ptr_zero   = (ptr_reg == '0);
    assign status.x_ge       = x_reg >= x_rd;
    assign status.den_zero   = (xm_reg == xn_reg);
    assign status.iter_last  = (cnt_reg == '0);
    assign status.out_free   = !m_valid_reg || m_ready;

    assign m_valid     = m_valid_reg;
    assign m_y_out     = m_y_reg;
    assign m_batch_end = m_last_reg;

endmodule

// ----- rtl/monotone_table_linear_interp.sv -----
// Top level of the clamped piecewise linear interpolator over a breakpoint table.
`timescale 1ns / 1ps
//
//  channel   direction  handshake              word
//  --------  ---------  ---------------------  ---------------------------------------------
//  cfg       in         cfg_valid / cfg_ready  cfg_table_len: breakpoints in use
//  s         in         s_valid / s_ready      req_type, point_index, x_value, y_value, last
//  m         out        m_valid / m_ready      y_out, batch_end
//
//  Sequence: a load word is accepted and then written to the RAMs. An interpolating
//  query steps the pointer over the breakpoints whose x it is at or above, each
//  step reading the x RAM through its registered read port and then comparing;
//  the multiply and divide are bit-serial. A clamp (pointer at the length, or
//  below the first x) and a zero-width interval skip the multiply and divide.
//  Reset: aresetn clears the sequencer, the interval pointer, the output
//  valid and sets table_len to 64; the breakpoint RAMs are not cleared.
//  Stalls: the result sits in an output register; the next word is taken
//  while it waits, and the sequencer holds only if a second result is ready
//  before the first one has been taken.
//
//  Configuration writes are always accepted (cfg_ready tied high) and are
//  meant to happen while no query is in flight.

module monotone_table_linear_interp #(
    parameter int TABLE_DEPTH = 64,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mtli_pkg::LEN_W-1:0]    cfg_table_len,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_req_type,
    input  logic [mtli_pkg::SLOT_W-1:0]   s_point_index,
    input  logic signed [DATA_WIDTH-1:0]  s_x_value,
    input  logic signed [DATA_WIDTH-1:0]  s_y_value,
    input  logic                          s_last_query,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [DATA_WIDTH-1:0]  m_y_out,
    output logic                          m_batch_end
);

    import mtli_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // The length register is a plain write target: never stall it.
    assign cfg_ready = 1'b1;

    // Sequencer: accept, walk the pointer forward, fetch the interval,
    // then drive the multiply and divide one bit per cycle.
    mtli_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Datapath: holds the table, the pointer, the arithmetic and the
    // output word register.
    mtli_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_table_len (cfg_table_len),
        .s_req_type    (s_req_type),
        .s_point_index (s_point_index),
        .s_x_value     (s_x_value),
        .s_y_value     (s_y_value),
        .s_last_query  (s_last_query),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_y_out       (m_y_out),
        .m_batch_end   (m_batch_end),
        .cmd           (cmd),
        .status        (status)
    );

endmodule
